// ----- sv/assert_macros.svh -----
// assertion macros used by the timer bank rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CTB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define CTB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ctb_pkg.sv -----
// shared constants, request codes and unit scaling for the countdown timer bank
package ctb_pkg;

   localparam int NUM_SLOTS_DEF = 16;

   localparam int DUR_W   = 32;
   localparam int FACT_W  = 22;
   localparam int MUL_W   = DUR_W + FACT_W;
   localparam int SLOT_W  = 4;

   // request codes
   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // unit codes
   localparam logic [1:0] UNIT_MS   = 2'd0;
   localparam logic [1:0] UNIT_SEC  = 2'd1;
   localparam logic [1:0] UNIT_MIN  = 2'd2;
   localparam logic [1:0] UNIT_HOUR = 2'd3;

   localparam logic [FACT_W-1:0] MS_PER_SEC  = FACT_W'(1000);
   localparam logic [FACT_W-1:0] MS_PER_MIN  = FACT_W'(1000 * 60);
   localparam logic [FACT_W-1:0] MS_PER_HOUR = FACT_W'(1000 * 60 * 60);

   function automatic logic [FACT_W-1:0] ms_factor(input logic [1:0] unit);
      logic [FACT_W-1:0] f;
      unique case (unit)
         UNIT_MS:   f = FACT_W'(1);
         UNIT_SEC:  f = MS_PER_SEC;
         UNIT_MIN:  f = MS_PER_MIN;
         UNIT_HOUR: f = MS_PER_HOUR;
         default:   f = FACT_W'(1);
      endcase
      return f;
   endfunction

endpackage

// ----- sv/countdown_timer_bank_unit.sv -----
// countdown timer bank: slot store, create/query/tick sequencer and result register
//
// Input channel req_*: one beat is a request. req_type picks create, query or
// tick; code 3 is taken and dropped. Result channel rsp_*: one beat per create
// or query, none for a tick. A create scales req_duration to milliseconds
// (saturating at 32 bits), puts it in the next free slot and returns that slot;
// a full bank gives error with slot 0. A query returns the slot's count and a
// running flag, or error for a slot not yet handed out.
// Create and query go through a second state (S_MUL or S_QRY) and then the
// result register to rsp_valid. A tick sweeps the used slots through one
// shared decrementer fed by a single-port read of the slot memory, one slot
// a cycle, and holds req_ready low until the sweep ends.
// req_ready is high only while the sequencer is idle, so a new request is not
// taken until the previous one has left its last state.
// Reset clears the fill count; slots past it read as zero, so the memory needs
// no clearing pass and req_ready is high from the first cycle after reset.
// A stalled receiver holds the result in the output register; a following
// create or query waits in its last step until that beat is taken.
module countdown_timer_bank_unit #(
   parameter int NUM_SLOTS = ctb_pkg::NUM_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [ctb_pkg::DUR_W-1:0]   req_duration,
   input  logic [1:0]                  req_unit,
   input  logic [ctb_pkg::SLOT_W-1:0]  req_slot_to_query,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ctb_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [ctb_pkg::DUR_W-1:0]   rsp_remaining_ms,
   output logic                        rsp_running,
   output logic                        rsp_error
);

`include "assert_macros.svh"

   localparam int AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW   = $clog2(NUM_SLOTS + 1);
   localparam int CMPW = (CW > ctb_pkg::SLOT_W) ? CW : ctb_pkg::SLOT_W;
   localparam int DW   = ctb_pkg::DUR_W;
   localparam int MW   = ctb_pkg::MUL_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_QRY  = 2'd2;
   localparam logic [1:0] S_TICK = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           used_ff, used_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [AW-1:0]           widx_ff, widx_in;
   logic                    rvld_ff, rvld_in;
   logic [MW-1:0]           prod_ff, prod_in;
   logic [ctb_pkg::SLOT_W-1:0] qslot_ff, qslot_in;
   logic [AW-1:0]           qaddr_ff, qaddr_in;
   logic                    qerr_ff, qerr_in;
   logic [DW-1:0]           rdata_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ctb_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [DW-1:0]           rsp_rem_ff, rsp_rem_in;
   logic                    rsp_err_ff, rsp_err_in;

   logic [DW-1:0]           mem [NUM_SLOTS];
   logic                    we;
   logic [AW-1:0]           waddr;
   logic [DW-1:0]           wdata;
   logic [AW-1:0]           raddr;

   logic                    req_fire;
   logic                    out_free;
   logic                    full;
   logic [CMPW-1:0]         q_ext;
   logic [CMPW-1:0]         used_ext;
   logic                    rd_go;
   logic [DW-1:0]           ms_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (used_ff == CW'(NUM_SLOTS));
   assign q_ext     = CMPW'(req_slot_to_query);
   assign used_ext  = CMPW'(used_ff);
   assign rd_go     = (idx_ff < used_ff);
   // saturate the scaled duration at 32 bits
   assign ms_sat    = (prod_ff[MW-1:DW] != '0) ? '1 : prod_ff[DW-1:0];

   always_comb begin
      priority case (state_ff)
         S_IDLE:  raddr = q_ext[AW-1:0];
         S_TICK:  raddr = idx_ff[AW-1:0];
         default: raddr = qaddr_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      widx_in      = widx_ff;
      rvld_in      = 1'b0;
      prod_in      = prod_ff;
      qslot_in     = qslot_ff;
      qaddr_in     = qaddr_ff;
      qerr_in      = qerr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_err_in   = rsp_err_ff;
      we           = 1'b0;
      waddr        = used_ff[AW-1:0];
      wdata        = ms_sat;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               priority case (req_type)
                  ctb_pkg::REQ_CREATE: begin
                     prod_in = req_duration * ctb_pkg::ms_factor(req_unit);
                     if (full) begin
                        qslot_in = '0;
                        qerr_in  = 1'b1;
                        state_in = S_QRY;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
                  ctb_pkg::REQ_QUERY: begin
                     qslot_in = req_slot_to_query;
                     qaddr_in = q_ext[AW-1:0];
                     qerr_in  = (q_ext >= used_ext);
                     state_in = S_QRY;
                  end
                  ctb_pkg::REQ_TICK: begin
                     idx_in   = '0;
                     state_in = S_TICK;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL: begin
            if (out_free) begin
               we           = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = used_ext[ctb_pkg::SLOT_W-1:0];
               rsp_rem_in   = ms_sat;
               rsp_err_in   = 1'b0;
               used_in      = CW'(used_ff + 1'b1);
               state_in     = S_IDLE;
            end
         end
         S_QRY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = qslot_ff;
               rsp_rem_in   = qerr_ff ? '0 : rdata_ff;
               rsp_err_in   = qerr_ff;
               state_in     = S_IDLE;
            end
         end
         S_TICK: begin
            // read slot idx while writing back, decremented unless zero, the slot read in the previous cycle
            if (rd_go) begin
               rvld_in = 1'b1;
               widx_in = idx_ff[AW-1:0];
               idx_in  = CW'(idx_ff + 1'b1);
            end
            if (rvld_ff) begin
               we    = (rdata_ff != '0);
               waddr = widx_ff;
               wdata = rdata_ff - 1'b1;
            end
            if (!rd_go && !rvld_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      widx_ff     <= widx_in;
      prod_ff     <= prod_in;
      qslot_ff    <= qslot_in;
      qaddr_ff    <= qaddr_in;
      qerr_ff     <= qerr_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_remaining_ms = rsp_rem_ff;
   assign rsp_running      = (rsp_rem_ff != '0);
   assign rsp_error        = rsp_err_ff;

   `CTB_ASSERT(a_used_bound, used_ff <= CW'(NUM_SLOTS), "fill count beyond bank size")
   `CTB_ASSERT_NXT(a_create_fills, (state_ff == S_MUL) && out_free,
      used_ff == CW'($past(used_ff) + 1'b1), "create did not advance fill count")
   `CTB_ASSERT_IMP(a_sweep_in_range, (state_ff == S_TICK) && rvld_ff,
      CW'(widx_ff) < used_ff, "tick sweep wrote past used slots")
   `CTB_ASSERT_IMP(a_write_states, we,
      (state_ff == S_TICK) || (state_ff == S_MUL), "slot write outside create or tick")

endmodule
